// ===== hw/rtl/aps_pkg.sv =====
package aps_pkg;

  // power states
  localparam logic [2:0] ST_OFF  = 3'd0;
  localparam logic [2:0] ST_BOOT = 3'd1;
  localparam logic [2:0] ST_ON   = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_SHUT = 3'd4;

  // start prediction states
  localparam logic [1:0] PR_IDLE      = 2'd0;
  localparam logic [1:0] PR_RECENT    = 2'd1;
  localparam logic [1:0] PR_NOTRECENT = 2'd2;
  localparam logic [1:0] PR_STARTING  = 2'd3;

  // shutdown-wait sub-phases
  localparam logic [1:0] PH_CONTACT_OFF   = 2'd0;
  localparam logic [1:0] PH_LOCK_INACTIVE = 2'd1;
  localparam logic [1:0] PH_LOCK_ACTIVE   = 2'd2;

  // register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_BOOT_TIMEOUT      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_TIMEOUT      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHUTDOWN_HOLD     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONTACT_OFF_DELAY = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECENT_LIMIT      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RELOCK_WINDOW     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LOCK_IGNORE_TIME  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CHARGE_AFTER      = 4'd7;

  localparam logic [15:0] BLINK_RECENT   = 16'd50;
  localparam logic [15:0] BRAKE_DELAY    = 16'd200;
  localparam logic [7:0]  START_GUARD    = 8'd100;
  localparam logic [15:0] BLINK_END_FAKE = 16'd1420;
  localparam logic [15:0] MAX16          = 16'hffff;
  localparam logic [7:0]  MAX8           = 8'hff;

  typedef struct packed {
    logic [15:0] boot_timeout;
    logic [15:0] wait_timeout;
    logic [15:0] shutdown_hold;
    logic [7:0]  contact_off_delay;
    logic [15:0] recent_limit;
    logic [15:0] relock_window;
    logic [15:0] lock_ignore_time;
    logic [15:0] charge_after;
  } cfg_t;

  typedef struct packed {
    logic accessory_on;
    logic contact_on;
    logic start_on;
    logic pump_on;
    logic lock_raw;
    logic blink_on;
  } item_t;

  typedef struct packed {
    logic [2:0]  sys_mode;
    logic [1:0]  wait_phase;
    logic [1:0]  predict_mode;
    logic [15:0] mode_timer;
    logic [15:0] predict_age;
    logic [15:0] since_blink;
    logic        blink_seen_waiting;
    logic [7:0]  contact_off_count;
    logic [7:0]  start_off_count;
    logic [15:0] pump_run_count;
    logic [15:0] since_unlock;
    logic [15:0] ignore_remaining;
    logic        lock_state;
    logic        lock_raw_prev;
  } state_t;

  typedef struct packed {
    logic       led_red;
    logic       led_grn;
    logic       radio_relay;
    logic       brake_out;
    logic       supply_select;
    logic       charge_enable;
    logic [2:0] system_state;
    logic [1:0] predict_state;
    logic       lock_filtered;
  } result_t;

  function automatic logic [15:0] inc16(input logic [15:0] v);
    return (v != MAX16) ? v + 16'd1 : v;
  endfunction

  function automatic logic [7:0] inc8(input logic [7:0] v);
    return (v != MAX8) ? v + 8'd1 : v;
  endfunction

endpackage

// ===== hw/rtl/accessory_power_sequencer.sv =====
// a request accepted into the input register moves on into the result register once
// that register is free or being drained
// throughput: one request per cycle while out_stall stays low; the step is a single
// pass of logic between the input register and the result register
// reset (rst, synchronous, active high) clears the sequencer state, empties both
// pipeline registers and loads the register defaults
module accessory_power_sequencer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            accessory_on,
  input  logic                            contact_on,
  input  logic                            start_on,
  input  logic                            pump_on,
  input  logic                            lock_raw,
  input  logic                            blink_on,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            led_red,
  output logic                            led_grn,
  output logic                            radio_relay,
  output logic                            brake_out,
  output logic                            supply_select,
  output logic                            charge_enable,
  output logic [2:0]                      system_state,
  output logic [1:0]                      predict_state,
  output logic                            lock_filtered,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [aps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aps_pkg::CFG_DATA_W-1:0]  cfg_data
);

  aps_pkg::cfg_t    cfg;
  aps_pkg::item_t   item;
  aps_pkg::state_t  state;
  aps_pkg::state_t  state_next;
  aps_pkg::result_t res;
  aps_pkg::result_t res_q;
  logic             item_valid;
  logic             advance;
  logic             in_take;

  aps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  aps_step u_step (
    .cfg        (cfg),
    .item       (item),
    .cur        (state),
    .state_next (state_next),
    .res        (res)
  );

  // the held request moves on whenever the result register is free or being drained
  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item.accessory_on <= accessory_on;
      item.contact_on   <= contact_on;
      item.start_on     <= start_on;
      item.pump_on      <= pump_on;
      item.lock_raw     <= lock_raw;
      item.blink_on     <= blink_on;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.sys_mode           <= aps_pkg::ST_OFF;
      state.wait_phase         <= aps_pkg::PH_CONTACT_OFF;
      state.predict_mode       <= aps_pkg::PR_IDLE;
      state.mode_timer         <= 16'd0;
      state.predict_age        <= 16'd0;
      state.since_blink        <= aps_pkg::MAX16;
      state.blink_seen_waiting <= 1'b0;
      state.contact_off_count  <= aps_pkg::MAX8;
      state.start_off_count    <= aps_pkg::MAX8;
      state.pump_run_count     <= 16'd0;
      state.since_unlock       <= aps_pkg::MAX16;
      state.ignore_remaining   <= aps_pkg::MAX16;
      state.lock_state         <= 1'b0;
      state.lock_raw_prev      <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign led_red       = res_q.led_red;
  assign led_grn       = res_q.led_grn;
  assign radio_relay   = res_q.radio_relay;
  assign brake_out     = res_q.brake_out;
  assign supply_select = res_q.supply_select;
  assign charge_enable = res_q.charge_enable;
  assign system_state  = res_q.system_state;
  assign predict_state = res_q.predict_state;
  assign lock_filtered = res_q.lock_filtered;

  // state only moves when a request is handed to the result register
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("sequencer state changed without a request");

  a_take_held: assert property (@(posedge clk) disable iff (rst)
    in_take |=> item_valid)
    else $error("accepted request not held");

  a_advance_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result lost after advance");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !item_valid |=> !out_valid)
    else $error("result repeated after being taken");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> item_valid && out_valid && out_stall)
    else $error("input stalled without a full pipeline");

endmodule

// ===== hw/rtl/aps_cfg.sv =====
module aps_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [aps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [aps_pkg::CFG_DATA_W-1:0]     cfg_data,
  output aps_pkg::cfg_t                      cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.boot_timeout      <= 16'd18000;
      cfg.wait_timeout      <= 16'd18000;
      cfg.shutdown_hold     <= 16'd10;
      cfg.contact_off_delay <= 8'd50;
      cfg.recent_limit      <= 16'd3000;
      cfg.relock_window     <= 16'd200;
      cfg.lock_ignore_time  <= 16'd12000;
      cfg.charge_after      <= 16'd1000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        aps_pkg::REG_BOOT_TIMEOUT:      cfg.boot_timeout      <= cfg_data;
        aps_pkg::REG_WAIT_TIMEOUT:      cfg.wait_timeout      <= cfg_data;
        aps_pkg::REG_SHUTDOWN_HOLD:     cfg.shutdown_hold     <= cfg_data;
        aps_pkg::REG_CONTACT_OFF_DELAY: cfg.contact_off_delay <= cfg_data[7:0];
        aps_pkg::REG_RECENT_LIMIT:      cfg.recent_limit      <= cfg_data;
        aps_pkg::REG_RELOCK_WINDOW:     cfg.relock_window     <= cfg_data;
        aps_pkg::REG_LOCK_IGNORE_TIME:  cfg.lock_ignore_time  <= cfg_data;
        aps_pkg::REG_CHARGE_AFTER:      cfg.charge_after      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/aps_step.sv =====
module aps_step (
  input  aps_pkg::cfg_t    cfg,
  input  aps_pkg::item_t   item,
  input  aps_pkg::state_t  cur,
  output aps_pkg::state_t  state_next,
  output aps_pkg::result_t res
);

  always_comb begin
    aps_pkg::state_t s;
    logic recent_blink;
    logic red, green, relay, brake, supply, charge;

    s = cur;
    red = 1'b1;
    green = 1'b1;
    relay = 1'b0;
    brake = 1'b0;

    // timers and counters
    s.mode_timer = aps_pkg::inc16(cur.mode_timer);
    s.predict_age = aps_pkg::inc16(cur.predict_age);
    s.since_blink = item.blink_on ? 16'd0 : aps_pkg::inc16(cur.since_blink);
    s.contact_off_count = item.contact_on ? 8'd0 : aps_pkg::inc8(cur.contact_off_count);
    s.start_off_count = item.start_on ? 8'd0 : aps_pkg::inc8(cur.start_off_count);
    s.pump_run_count = item.pump_on ? aps_pkg::inc16(cur.pump_run_count) : 16'd0;

    // start prediction
    case (cur.predict_mode)
      aps_pkg::PR_IDLE: begin
        if (item.contact_on) begin
          s.predict_mode = aps_pkg::PR_RECENT;
          s.predict_age = 16'd0;
          s.contact_off_count = 8'd0;
        end
      end
      aps_pkg::PR_RECENT, aps_pkg::PR_NOTRECENT: begin
        if (item.start_on) begin
          s.predict_mode = aps_pkg::PR_STARTING;
          s.predict_age = 16'd0;
        end else if (!item.contact_on && s.contact_off_count > cfg.contact_off_delay) begin
          s.predict_mode = aps_pkg::PR_IDLE;
          s.predict_age = 16'd0;
        end else if (s.predict_age > cfg.recent_limit
                     && cur.predict_mode == aps_pkg::PR_RECENT) begin
          s.predict_mode = aps_pkg::PR_NOTRECENT;
          s.predict_age = 16'd0;
        end
      end
      default: begin
        if (item.contact_on && !item.start_on) begin
          s.predict_mode = aps_pkg::PR_NOTRECENT;
          s.predict_age = 16'd0;
        end
      end
    endcase

    // relay choice
    if (s.start_off_count < aps_pkg::START_GUARD) begin
      supply = 1'b0;
      charge = 1'b0;
    end else if (s.pump_run_count > cfg.charge_after && item.contact_on) begin
      supply = 1'b1;
      charge = 1'b1;
    end else if (s.predict_mode == aps_pkg::PR_RECENT) begin
      supply = 1'b0;
      charge = 1'b0;
    end else begin
      supply = 1'b1;
      charge = 1'b0;
    end

    // lock filter: a re-lock soon after unlock is ignored for a while
    if (!item.lock_raw && cur.lock_raw_prev) begin
      s.since_unlock = 16'd0;
      s.lock_state = 1'b0;
    end else if (item.lock_raw) begin
      if (!cur.lock_raw_prev) begin
        s.ignore_remaining = (cur.since_unlock < cfg.relock_window) ?
                             cfg.lock_ignore_time : 16'd0;
      end
      if (s.ignore_remaining != 16'd0) begin
        if (item.blink_on && s.ignore_remaining < aps_pkg::BLINK_END_FAKE) begin
          s.ignore_remaining = 16'd0;
          s.lock_state = 1'b1;
        end else begin
          s.ignore_remaining = s.ignore_remaining - 16'd1;
          s.lock_state = 1'b0;
        end
      end else begin
        s.lock_state = 1'b1;
      end
    end
    s.lock_raw_prev = item.lock_raw;
    s.since_unlock = aps_pkg::inc16(s.since_unlock);

    // power state machine
    recent_blink = s.since_blink < aps_pkg::BLINK_RECENT;
    case (cur.sys_mode)
      aps_pkg::ST_BOOT: begin
        red = 1'b1;
        green = 1'b0;
        relay = 1'b1;
        brake = s.mode_timer > aps_pkg::BRAKE_DELAY;
        if (item.accessory_on) begin
          s.sys_mode = aps_pkg::ST_ON;
          s.mode_timer = 16'd0;
        end else if (s.lock_state && recent_blink) begin
          s.sys_mode = aps_pkg::ST_SHUT;
          s.mode_timer = 16'd0;
        end else if (item.blink_on) begin
          s.mode_timer = 16'd0;
        end else if (s.mode_timer > cfg.boot_timeout) begin
          s.sys_mode = aps_pkg::ST_SHUT;
          s.mode_timer = 16'd0;
        end
      end
      aps_pkg::ST_ON: begin
        red = 1'b0;
        green = 1'b0;
        relay = 1'b1;
        brake = 1'b1;
        if (!item.accessory_on) begin
          s.blink_seen_waiting = 1'b0;
          s.wait_phase = aps_pkg::PH_CONTACT_OFF;
          s.sys_mode = aps_pkg::ST_WAIT;
          s.mode_timer = 16'd0;
        end
      end
      aps_pkg::ST_WAIT: begin
        red = 1'b0;
        green = 1'b1;
        relay = 1'b1;
        brake = 1'b1;
        s.blink_seen_waiting = cur.blink_seen_waiting || item.blink_on;
        if (cur.wait_phase == aps_pkg::PH_CONTACT_OFF) begin
          if (!s.lock_state) s.wait_phase = aps_pkg::PH_LOCK_INACTIVE;
        end else if (cur.wait_phase == aps_pkg::PH_LOCK_INACTIVE) begin
          if (s.lock_state && s.blink_seen_waiting) s.wait_phase = aps_pkg::PH_LOCK_ACTIVE;
        end
        if (item.accessory_on) begin
          s.sys_mode = aps_pkg::ST_ON;
          s.mode_timer = 16'd0;
        end else if (s.mode_timer > cfg.wait_timeout) begin
          s.sys_mode = aps_pkg::ST_SHUT;
          s.mode_timer = 16'd0;
        end else if (s.wait_phase == aps_pkg::PH_LOCK_ACTIVE) begin
          s.sys_mode = aps_pkg::ST_SHUT;
          s.mode_timer = 16'd0;
        end
      end
      aps_pkg::ST_SHUT: begin
        red = 1'b0;
        green = 1'b1;
        relay = 1'b1;
        brake = 1'b1;
        if (s.mode_timer >= cfg.shutdown_hold) begin
          s.sys_mode = aps_pkg::ST_OFF;
          s.mode_timer = 16'd0;
        end
      end
      default: begin
        // off, and the unused codes behave as off
        red = 1'b1;
        green = 1'b1;
        relay = 1'b0;
        brake = 1'b0;
        if (item.accessory_on || (recent_blink && !s.lock_state)) begin
          s.sys_mode = aps_pkg::ST_BOOT;
          s.mode_timer = 16'd0;
        end
      end
    endcase

    state_next = s;
    res.led_red = red;
    res.led_grn = green;
    res.radio_relay = relay;
    res.brake_out = brake;
    res.supply_select = supply;
    res.charge_enable = charge;
    res.system_state = s.sys_mode;
    res.predict_state = s.predict_mode;
    res.lock_filtered = s.lock_state;
  end

endmodule
